// ===== rtl/core/tedq_pkg.sv =====
// shared types for the tagged entry deque: command and status codes,
// the entry record and the control bundle that drives the row of cells
// no dependencies
`default_nettype none

package tedq_pkg;

    localparam int VALUE_W = 64;
    localparam int KIND_W  = 5;
    localparam int PRIO_W  = 3;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  kind;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    // row shift and back-write strobes, already gated by the accepted request
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/tagged_entry_deque_core.sv =====
// top level of the tagged entry deque: command decode, fill count, the row
// of tedq_cell slots, the back-entry read tree and the two result registers
// depends on tedq_pkg and tedq_cell
//
// usage:
//   request channel i_valid / o_stall carries i_cmd and the entry to push;
//   result channel o_valid / i_stall returns one result per request with
//   status, the entry read (zero when none), fill count and empty flag.
//   the front entry always sits in slot 0; front pushes and pops shift the
//   whole row by one slot, back pushes write the first free slot.
//   the back entry is picked by a one-hot OR tree that is registered once
//   after eight-slot groups; a result goes through the middle stage and the
//   output register, and one request per cycle is sustained unless stalled.
//   when the result side stalls, the finished result waits in the output
//   register and one more request is still taken into the middle stage;
//   after that o_stall rises until the output drains.
//   reset (synchronous, active low) empties the deque and drops pending
//   results; slot contents are not cleared and never read before written.
`default_nettype none

module tagged_entry_deque_core #(
    parameter int DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [2:0]                     i_cmd,
    input  wire logic [tedq_pkg::VALUE_W-1:0]   i_in_value,
    input  wire logic [tedq_pkg::KIND_W-1:0]    i_in_kind,
    input  wire logic [tedq_pkg::PRIO_W-1:0]    i_in_priority,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [1:0]                          o_status,
    output logic                                o_item_valid,
    output logic [tedq_pkg::VALUE_W-1:0]        o_out_value,
    output logic [tedq_pkg::KIND_W-1:0]         o_out_kind,
    output logic [tedq_pkg::PRIO_W-1:0]         o_out_priority,
    output logic [$clog2(DEPTH+1)-1:0]          o_fill_count,
    output logic                                o_is_empty
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int GS = 8;
    localparam int NG = (DEPTH + GS - 1) / GS;

    // request decode
    tedq_pkg::t_cmd       w_cmd;
    tedq_pkg::t_entry     w_in_entry;
    tedq_pkg::t_cell_ctrl w_ctrl;
    tedq_pkg::t_status    w_status;
    logic                 w_acc;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_got;
    logic                 w_use_back;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;

    // cell row
    tedq_pkg::t_entry     w_data [DEPTH];
    tedq_pkg::t_entry     w_back_pad [NG*GS];

    // middle stage
    logic                 r_a_valid;
    tedq_pkg::t_status    r_a_status;
    logic                 r_a_got;
    logic                 r_a_use_back;
    tedq_pkg::t_entry     r_a_front;
    tedq_pkg::t_entry     r_a_grp [NG];
    logic [CW-1:0]        r_a_count;
    tedq_pkg::t_entry     w_back_all;
    tedq_pkg::t_entry     w_sel;
    logic                 w_b_load;

    // output stage
    logic                 r_o_valid;
    tedq_pkg::t_status    r_o_status;
    logic                 r_o_got;
    tedq_pkg::t_entry     r_o_entry;
    logic [CW-1:0]        r_o_count;

    assign w_cmd      = tedq_pkg::t_cmd'(i_cmd);
    assign w_in_entry = '{value: i_in_value, kind: i_in_kind, prio: i_in_priority};
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_b_load = r_a_valid && (!r_o_valid || !i_stall);
    assign o_stall  = r_a_valid && !w_b_load;
    assign w_acc    = i_valid && !o_stall;

    always_comb begin
        n_count    = r_count;
        w_status   = tedq_pkg::ST_OK;
        w_got      = 1'b0;
        w_use_back = 1'b0;
        w_ctrl     = '0;
        unique case (w_cmd)
            tedq_pkg::CMD_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = tedq_pkg::ST_FULL;
                end else begin
                    w_ctrl.push_front = w_acc;
                    n_count           = r_count + CW'(1);
                end
            end
            tedq_pkg::CMD_PUSH_BACK: begin
                if (w_full) begin
                    w_status = tedq_pkg::ST_FULL;
                end else begin
                    w_ctrl.push_back = w_acc;
                    n_count          = r_count + CW'(1);
                end
            end
            tedq_pkg::CMD_POP_FRONT: begin
                if (w_empty) begin
                    w_status = tedq_pkg::ST_EMPTY;
                end else begin
                    w_got            = 1'b1;
                    w_ctrl.pop_front = w_acc;
                    n_count          = r_count - CW'(1);
                end
            end
            tedq_pkg::CMD_POP_BACK: begin
                if (w_empty) begin
                    w_status = tedq_pkg::ST_EMPTY;
                end else begin
                    w_got      = 1'b1;
                    w_use_back = 1'b1;
                    n_count    = r_count - CW'(1);
                end
            end
            tedq_pkg::CMD_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = tedq_pkg::ST_EMPTY;
                end else begin
                    w_got = 1'b1;
                end
            end
            tedq_pkg::CMD_PEEK_BACK: begin
                if (w_empty) begin
                    w_status = tedq_pkg::ST_EMPTY;
                end else begin
                    w_got      = 1'b1;
                    w_use_back = 1'b1;
                end
            end
            tedq_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    // the row: slot 0 is the front, slot count-1 the back
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        tedq_pkg::t_entry w_left;
        tedq_pkg::t_entry w_right;

        if (i == 0) begin : g_first
            assign w_left = w_in_entry;
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_right = w_data[i];
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end

        tedq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_count (r_count),
            .i_entry (w_in_entry),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[i]),
            .o_back  (w_back_pad[i])
        );
    end

    for (genvar p = DEPTH; p < NG*GS; p++) begin : g_pad
        assign w_back_pad[p] = '0;
    end

    // first level of the back-entry tree, registered with the request
    for (genvar g = 0; g < NG; g++) begin : g_grp
        tedq_pkg::t_entry w_or;

        always_comb begin
            w_or = '0;
            for (int j = 0; j < GS; j++) begin
                w_or = w_or | w_back_pad[g*GS + j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_acc) begin
                r_a_grp[g] <= w_or;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_acc || (r_a_valid && !w_b_load);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_status   <= w_status;
            r_a_got      <= w_got;
            r_a_use_back <= w_use_back;
            r_a_front    <= w_data[0];
            r_a_count    <= n_count;
        end
    end

    always_comb begin
        w_back_all = '0;
        for (int g = 0; g < NG; g++) begin
            w_back_all = w_back_all | r_a_grp[g];
        end
    end

    assign w_sel = r_a_use_back ? w_back_all : r_a_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w_b_load || (r_o_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_load) begin
            r_o_status <= r_a_status;
            r_o_got    <= r_a_got;
            r_o_entry  <= r_a_got ? w_sel : '0;
            r_o_count  <= r_a_count;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_item_valid   = r_o_got;
    assign o_out_value    = r_o_entry.value;
    assign o_out_kind     = r_o_entry.kind;
    assign o_out_priority = r_o_entry.prio;
    assign o_fill_count   = r_o_count;
    assign o_is_empty     = (r_o_count == '0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd == tedq_pkg::CMD_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the deque");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == tedq_pkg::ST_FULL) |-> (o_fill_count == CW'(DEPTH)))
        else $error("full status while not full");

    a_item_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_valid) |-> (o_status == tedq_pkg::ST_OK))
        else $error("entry returned with an error status");

    a_stall_holds_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_b_load) |=> (r_a_valid && $stable(r_a_count)))
        else $error("pending request lost in middle stage");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tedq_cell.sv =====
// one slot of the deque row: holds an entry, takes it from its left or
// right neighbor on front pushes and pops, or from the input on a back push
// depends on tedq_pkg
`default_nettype none

module tedq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire logic                 i_clk,
    input  wire tedq_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [CW-1:0]        i_count,
    input  wire tedq_pkg::t_entry     i_entry,
    input  wire tedq_pkg::t_entry     i_left,
    input  wire tedq_pkg::t_entry     i_right,
    output tedq_pkg::t_entry          o_data,
    output tedq_pkg::t_entry          o_back
);

    tedq_pkg::t_entry r_data;
    tedq_pkg::t_entry n_data;
    logic             w_is_slot;
    logic             w_is_back;

    // first free slot and current back entry
    assign w_is_slot = (i_count == CW'(IDX));
    assign w_is_back = (i_count == CW'(IDX + 1));

    always_comb begin
        if (i_ctrl.push_front) begin
            n_data = i_left;
        end else if (i_ctrl.pop_front) begin
            n_data = i_right;
        end else if (i_ctrl.push_back && w_is_slot) begin
            n_data = i_entry;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_back = w_is_back ? r_data : '0;

endmodule

`default_nettype wire

// ===== tb/tagged_entry_deque_core_tb.sv =====
// self-checking testbench for tagged_entry_deque_core: directed table then random requests
// under random stalls and one long result-side hold-off, replies checked against a ring model
// depends on tedq_pkg and the tagged_entry_deque_core rtl
module tagged_entry_deque_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int FILL_W       = $clog2(DEPTH + 1);
    localparam int RAND_ITEMS   = 1380;
    localparam int CHUNK        = 120;
    localparam int IDLE_PCT     = 27;
    localparam int CALM_LO      = 800;
    localparam int CALM_HI      = 1000;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 20;

    // command code seven has no name in the package
    localparam logic [2:0] CMD_SPARE = 3'd7;

    typedef struct packed {
        logic [1:0]                  status;
        logic                        item_valid;
        logic [tedq_pkg::VALUE_W-1:0] value;
        logic [tedq_pkg::KIND_W-1:0]  kind;
        logic [tedq_pkg::PRIO_W-1:0]  prio;
        logic [FILL_W-1:0]           fill;
        logic                        empty;
    } t_reply;

    typedef struct packed {
        logic [2:0]       cmd;
        tedq_pkg::t_entry ent;
        logic             typed;
        t_reply           want;
    } t_request;

    typedef struct packed {
        logic [2:0]                  cmd;
        logic [tedq_pkg::VALUE_W-1:0] value;
        logic [tedq_pkg::KIND_W-1:0]  kind;
        logic [tedq_pkg::PRIO_W-1:0]  prio;
        logic                        typed;
        logic [1:0]                  status;
        logic [FILL_W-1:0]           fill;
        logic                        empty;
    } t_dir_row;

    // typed rows expect no entry read, so only status, fill and empty flag are listed
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{tedq_pkg::CMD_POP_FRONT, 64'd0, 5'd0, 3'd0,
          1'b1, tedq_pkg::ST_EMPTY, 7'd0, 1'b1},
        '{tedq_pkg::CMD_POP_BACK, 64'd0, 5'd0, 3'd0,
          1'b1, tedq_pkg::ST_EMPTY, 7'd0, 1'b1},
        '{tedq_pkg::CMD_PEEK_FRONT, 64'd0, 5'd0, 3'd0,
          1'b1, tedq_pkg::ST_EMPTY, 7'd0, 1'b1},
        '{tedq_pkg::CMD_PEEK_BACK, 64'd0, 5'd0, 3'd0,
          1'b1, tedq_pkg::ST_EMPTY, 7'd0, 1'b1},
        '{tedq_pkg::CMD_PUSH_BACK, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 3'd7,
          1'b1, tedq_pkg::ST_OK, 7'd1, 1'b0},
        '{tedq_pkg::CMD_PUSH_FRONT, 64'd0, 5'd0, 3'd0,
          1'b1, tedq_pkg::ST_OK, 7'd2, 1'b0},
        '{tedq_pkg::CMD_PEEK_FRONT, 64'd0, 5'd0, 3'd0,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_PEEK_BACK, 64'd0, 5'd0, 3'd0,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_POP_BACK, 64'd0, 5'd0, 3'd0,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_POP_FRONT, 64'd0, 5'd0, 3'd0,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{CMD_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 3'd7,
          1'b1, tedq_pkg::ST_OK, 7'd0, 1'b1},
        '{tedq_pkg::CMD_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA, 5'h15, 3'd5,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_PUSH_BACK, 64'h5555_5555_5555_5555, 5'h0A, 3'd2,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_PUSH_FRONT, 64'h8000_0000_0000_0001, 5'h10, 3'd4,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_POP_BACK, 64'd0, 5'd0, 3'd0,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_PEEK_FRONT, 64'd0, 5'd0, 3'd0,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_CLEAR, 64'd0, 5'd0, 3'd0,
          1'b1, tedq_pkg::ST_OK, 7'd0, 1'b1},
        '{tedq_pkg::CMD_PEEK_BACK, 64'd0, 5'd0, 3'd0,
          1'b1, tedq_pkg::ST_EMPTY, 7'd0, 1'b1},
        '{tedq_pkg::CMD_PUSH_BACK, 64'h7FF0_0000_0000_0000, 5'd1, 3'd1,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0},
        '{tedq_pkg::CMD_POP_FRONT, 64'd0, 5'd0, 3'd0,
          1'b0, tedq_pkg::ST_OK, 7'd0, 1'b0}
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [2:0]                   i_cmd = tedq_pkg::CMD_CLEAR;
    logic [tedq_pkg::VALUE_W-1:0] i_in_value = '0;
    logic [tedq_pkg::KIND_W-1:0]  i_in_kind = '0;
    logic [tedq_pkg::PRIO_W-1:0]  i_in_priority = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [1:0]                   o_status;
    logic                         o_item_valid;
    logic [tedq_pkg::VALUE_W-1:0] o_out_value;
    logic [tedq_pkg::KIND_W-1:0]  o_out_kind;
    logic [tedq_pkg::PRIO_W-1:0]  o_out_priority;
    logic [FILL_W-1:0]            o_fill_count;
    logic                         o_is_empty;

    tagged_entry_deque_core #(.DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_in_value     (i_in_value),
        .i_in_kind      (i_in_kind),
        .i_in_priority  (i_in_priority),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_item_valid   (o_item_valid),
        .o_out_value    (o_out_value),
        .o_out_kind     (o_out_kind),
        .o_out_priority (o_out_priority),
        .o_fill_count   (o_fill_count),
        .o_is_empty     (o_is_empty)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // deque shadow: ring of entries, front slot and number held
    tedq_pkg::t_entry  ring_mem [DEPTH];
    logic [SLOT_W-1:0] front_slot = '0;
    logic [FILL_W-1:0] held = '0;

    t_request    request_q [$];
    t_reply      reply_q [$];
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned n_full_hits = 0;
    int unsigned n_empty_hits = 0;
    logic        hold_off = 1'b0;
    int unsigned quiet_cycles = 0;

    function automatic t_reply predict_deque_reply(logic [2:0] cmd, tedq_pkg::t_entry ent);
        t_reply            r;
        logic [SLOT_W-1:0] slot;
        r = '0;
        case (cmd) inside
            tedq_pkg::CMD_PUSH_FRONT, tedq_pkg::CMD_PUSH_BACK: begin
                if (held == FILL_W'(DEPTH)) begin
                    r.status = tedq_pkg::ST_FULL;
                end else begin
                    if (cmd == tedq_pkg::CMD_PUSH_FRONT) begin
                        front_slot = front_slot - 1'b1;
                        slot = front_slot;
                    end else begin
                        slot = front_slot + held[SLOT_W-1:0];
                    end
                    ring_mem[slot] = ent;
                    held = held + 1'b1;
                end
            end
            tedq_pkg::CMD_POP_FRONT, tedq_pkg::CMD_POP_BACK,
            tedq_pkg::CMD_PEEK_FRONT, tedq_pkg::CMD_PEEK_BACK: begin
                if (held == 0) begin
                    r.status = tedq_pkg::ST_EMPTY;
                end else begin
                    if (cmd == tedq_pkg::CMD_POP_FRONT || cmd == tedq_pkg::CMD_PEEK_FRONT)
                        slot = front_slot;
                    else
                        slot = front_slot + held[SLOT_W-1:0] - 1'b1;
                    r.item_valid = 1'b1;
                    r.value = ring_mem[slot].value;
                    r.kind = ring_mem[slot].kind;
                    r.prio = ring_mem[slot].prio;
                    if (cmd == tedq_pkg::CMD_POP_FRONT) begin
                        front_slot = front_slot + 1'b1;
                        held = held - 1'b1;
                    end else if (cmd == tedq_pkg::CMD_POP_BACK) begin
                        held = held - 1'b1;
                    end
                end
            end
            tedq_pkg::CMD_CLEAR: begin
                held = '0;
                front_slot = '0;
            end
            default: ;
        endcase
        r.fill = held;
        r.empty = (held == 0);
        return r;
    endfunction

    // push_pct steers the fill level: high drives the ring full, low drains it
    function automatic t_request random_request(int unsigned push_pct);
        t_request    req;
        int unsigned roll;
        req = '0;
        roll = $urandom_range(0, 99);
        if (roll == 0)
            req.cmd = tedq_pkg::CMD_CLEAR;
        else if (roll == 1)
            req.cmd = CMD_SPARE;
        else if ($urandom_range(0, 99) < push_pct)
            req.cmd = 3'($urandom_range(tedq_pkg::CMD_PUSH_FRONT, tedq_pkg::CMD_PUSH_BACK));
        else
            req.cmd = 3'($urandom_range(tedq_pkg::CMD_POP_FRONT, tedq_pkg::CMD_PEEK_BACK));
        case ($urandom_range(0, 9))
            0: req.ent.value = '0;
            1: req.ent.value = '1;
            default: req.ent.value = {$urandom, $urandom};
        endcase
        req.ent.kind = tedq_pkg::KIND_W'($urandom_range(0, 31));
        req.ent.prio = tedq_pkg::PRIO_W'($urandom_range(0, 7));
        return req;
    endfunction

    // reply check first, then request side, so ordering within the edge is fixed
    always @(posedge i_clk) begin : request_side
        t_reply      got;
        t_reply      want;
        t_request    req;
        int unsigned nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_status, o_item_valid, o_out_value, o_out_kind, o_out_priority,
                        o_fill_count, o_is_empty};
                n_results <= n_results + 1;
                if (reply_q.size() == 0) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < REPORT_MAX)
                        $display("reply %0d arrived with nothing outstanding", n_results);
                end else begin
                    want = reply_q.pop_front();
                    if (got !== want) begin
                        n_errors <= n_errors + 1;
                        if (n_errors < REPORT_MAX) begin
                            $display("reply %0d mismatch (exp/act): status %0d/%0d item %0b/%0b",
                                     n_results, want.status, got.status,
                                     want.item_valid, got.item_valid);
                            $display("  value %h/%h kind %0d/%0d prio %0d/%0d",
                                     want.value, got.value, want.kind, got.kind,
                                     want.prio, got.prio);
                            $display("  fill %0d/%0d empty %0b/%0b",
                                     want.fill, got.fill, want.empty, got.empty);
                        end
                    end
                end
            end

            nxt = n_accepted;
            if (i_valid && !o_stall) begin
                req = request_q[nxt];
                want = predict_deque_reply(req.cmd, req.ent);
                if (want.status == tedq_pkg::ST_FULL)
                    n_full_hits <= n_full_hits + 1;
                if (want.status == tedq_pkg::ST_EMPTY)
                    n_empty_hits <= n_empty_hits + 1;
                reply_q.push_back(req.typed ? req.want : want);
                nxt = nxt + 1;
                n_accepted <= nxt;
            end

            // a stalled request stays on the wires untouched
            if (!(i_valid && o_stall)) begin
                if (nxt < request_q.size() &&
                    ((nxt >= CALM_LO && nxt < CALM_HI) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    req = request_q[nxt];
                    i_valid <= 1'b1;
                    i_cmd <= req.cmd;
                    i_in_value <= req.ent.value;
                    i_in_kind <= req.ent.kind;
                    i_in_priority <= req.ent.prio;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else if (hold_off)
            i_stall <= 1'b1;
        else if (n_results >= CALM_LO && n_results < CALM_HI)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // long result-side hold while requests keep coming, to fill the pipe and back up
    initial begin : result_hold
        while (n_accepted < HOLD_AT)
            @(negedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, stopping", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : run
        t_request    req;
        int unsigned push_pct;
        for (int i = 0; i < DIR_ROWS; i++) begin
            req.cmd = dir_rows[i].cmd;
            req.ent = '{dir_rows[i].value, dir_rows[i].kind, dir_rows[i].prio};
            req.typed = dir_rows[i].typed;
            req.want = '{dir_rows[i].status, 1'b0, '0, '0, '0, dir_rows[i].fill,
                         dir_rows[i].empty};
            request_q.push_back(req);
        end
        push_pct = 90;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i != 0 && i % CHUNK == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 90;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            request_q.push_back(random_request(push_pct));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < request_q.size() || reply_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("ran %0d requests (%0d from the table), %0d replies checked",
                 n_accepted, DIR_ROWS, n_results);
        $display("pushes refused when full: %0d, reads on an empty deque: %0d",
                 n_full_hits, n_empty_hits);
        if (n_errors == 0 && reply_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
